[sv/trme_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trme_pkg - shared types and constants of the toy machine execute core
// Opcodes, status codes, data memory request type and the bit-reverse helper.
// ----------------------------------------------------------------------------
package trme_pkg;

  // storage geometry
  localparam int MEM_ADDR_BITS = 15;
  localparam int VALUE_BITS    = 19;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_BITS  = $clog2(NUM_REGS);

  // fixed widths of instruction fields and result fields
  localparam int INSTR_BITS     = 32;
  localparam int OPCODE_BITS    = 4;
  localparam int CONST_BITS     = 19;
  localparam int ADDR_FIELD_BITS = 15;
  localparam int OUT_VALUE_BITS = 19;
  localparam int OUT_ADDR_BITS  = 15;
  localparam int STATUS_BITS    = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_LOAD_CONST = 4'd0,
    OP_STORE      = 4'd7,
    OP_BITREV     = 4'd12,
    OP_LOAD_MEM   = 4'd15
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_REG_EMPTY = 2'd1,
    ST_MEM_EMPTY = 2'd2,
    ST_ILLEGAL   = 2'd3
  } status_t;

  typedef logic [MEM_ADDR_BITS-1:0] mem_addr_t;
  typedef logic [VALUE_BITS-1:0]    value_t;
  typedef logic [REG_IDX_BITS-1:0]  reg_idx_t;

  // one access to the data memory
  typedef struct packed {
    logic      en;
    logic      we;
    mem_addr_t addr;
    value_t    wdata;
  } dmem_req_t;

  // swap bit 0 and bit 2 of a three-bit value
  function automatic logic [2:0] rev3(input logic [2:0] v);
    rev3 = {v[0], v[1], v[2]};
  endfunction

endpackage
`default_nettype wire

[sv/toy_register_memory_machine_execute_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// toy_register_memory_machine_execute_core - executes one instruction per item
// Eight-register machine with a 2^15 word data memory: load constant, load
// from memory, store to memory, and bit-reverse through a register pointer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid / in_stall     | instr_word
//   out     | output    | out_valid / out_stall   | status, reg_written,
//           |           |                         | reg_index, reg_value,
//           |           |                         | mem_written, mem_address
//
// An item is accepted every cycle when the output side keeps up and the memory
// is not being cleared; its result passes through the middle stage and then
// the output register (register read and memory access in the accepting cycle,
// then result formation and register write-back through the output register).
// After reset the data memory is swept to zero, all 32768 words, during
// which in_stall stays high.
// A stalled output holds its item; the middle stage then holds too and
// in_stall rises until the output register drains.
// ----------------------------------------------------------------------------
module toy_register_memory_machine_execute_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [31:0] instr_word,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  status,
  output      logic        reg_written,
  output      logic [2:0]  reg_index,
  output      logic [18:0] reg_value,
  output      logic        mem_written,
  output      logic [14:0] mem_address
);
  import trme_pkg::*;

  // register file and memory interface
  value_t    regs [NUM_REGS];
  dmem_req_t dmem_req;
  value_t    dmem_rdata;
  logic      dmem_busy;

  // decode of the incoming item
  opcode_t   in_op;
  reg_idx_t  rd_idx;
  value_t    rd_val;
  logic      in_accept;
  logic      ptr_zero;
  logic [ADDR_FIELD_BITS-1:0] ld_field;
  logic [ADDR_FIELD_BITS-1:0] st_field;

  // middle stage
  logic      s1_valid;
  opcode_t   s1_op;
  reg_idx_t  s1_dest;
  value_t    s1_const;
  logic      s1_ptr_zero;
  mem_addr_t s1_maddr;
  logic      s1_adv;

  // middle stage results
  status_t   r_status;
  logic      r_rw;
  reg_idx_t  r_idx;
  value_t    r_val;
  logic      r_mw;
  mem_addr_t r_maddr;

  // output register
  status_t   o_status;
  logic      o_rw;
  reg_idx_t  o_idx;
  value_t    o_val;
  logic      o_mw;
  mem_addr_t o_maddr;

  // handshakes
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = dmem_busy || (s1_valid && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  // field extraction
  assign in_op    = opcode_t'(instr_word[OPCODE_BITS-1:0]);
  assign ld_field = instr_word[21:7];
  assign st_field = instr_word[18:4];
  assign rd_idx   = (in_op == OP_STORE) ? reg_idx_t'(instr_word[21:19])
                                        : reg_idx_t'(instr_word[9:7]);

  // register read with forwarding of the write still in the middle stage
  always_comb begin
    if (s1_valid && r_rw && (r_idx == rd_idx)) begin
      rd_val = r_val;
    end else begin
      rd_val = regs[rd_idx];
    end
  end

  assign ptr_zero = (rd_val == '0);

  // memory access issued at acceptance
  always_comb begin
    dmem_req    = '0;
    dmem_req.wdata = rd_val;
    case (in_op)
      OP_LOAD_MEM: begin
        dmem_req.en   = in_accept;
        dmem_req.addr = MEM_ADDR_BITS'(ld_field);
      end
      OP_STORE: begin
        dmem_req.en   = in_accept;
        dmem_req.we   = 1'b1;
        dmem_req.addr = MEM_ADDR_BITS'(st_field);
      end
      OP_BITREV: begin
        dmem_req.en   = in_accept && !ptr_zero;
        dmem_req.addr = MEM_ADDR_BITS'(rd_val);
      end
      default: begin
        dmem_req.en = 1'b0;
      end
    endcase
  end

  trme_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .req   (dmem_req),
    .rdata (dmem_rdata),
    .busy  (dmem_busy)
  );

  // middle stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // middle stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op       <= in_op;
      s1_dest     <= (in_op == OP_LOAD_CONST) ? reg_idx_t'(instr_word[25:23])
                                              : reg_idx_t'(instr_word[6:4]);
      s1_const    <= VALUE_BITS'(instr_word[22:4]);
      s1_ptr_zero <= ptr_zero;
      s1_maddr    <= MEM_ADDR_BITS'(st_field);
    end
  end

  // result formation from decode and memory read data
  always_comb begin
    r_status = ST_OK;
    r_rw     = 1'b0;
    r_idx    = '0;
    r_val    = '0;
    r_mw     = 1'b0;
    r_maddr  = '0;
    case (s1_op)
      OP_LOAD_CONST: begin
        r_rw  = 1'b1;
        r_idx = s1_dest;
        r_val = s1_const;
      end
      OP_LOAD_MEM: begin
        r_rw  = 1'b1;
        r_idx = s1_dest;
        r_val = dmem_rdata;
      end
      OP_STORE: begin
        r_mw    = 1'b1;
        r_maddr = s1_maddr;
      end
      OP_BITREV: begin
        if (s1_ptr_zero) begin
          r_status = ST_REG_EMPTY;
        end else if (dmem_rdata == '0) begin
          r_status = ST_MEM_EMPTY;
        end else begin
          r_rw  = 1'b1;
          r_idx = s1_dest;
          r_val = VALUE_BITS'(rev3(dmem_rdata[2:0]));
        end
      end
      default: begin
        r_status = ST_ILLEGAL;
      end
    endcase
  end

  // register file write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (s1_adv && r_rw) begin
      regs[r_idx] <= r_val;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_status <= r_status;
      o_rw     <= r_rw;
      o_idx    <= r_idx;
      o_val    <= r_val;
      o_mw     <= r_mw;
      o_maddr  <= r_maddr;
    end
  end

  assign status      = o_status;
  assign reg_written = o_rw;
  assign reg_index   = o_idx;
  assign reg_value   = OUT_VALUE_BITS'(o_val);
  assign mem_written = o_mw;
  assign mem_address = OUT_ADDR_BITS'(o_maddr);

endmodule
`default_nettype wire

[sv/trme_dmem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trme_dmem - data memory of the execute core
// Single-port synchronous memory with registered read data. After reset it
// sweeps every word to zero, one word a cycle, and reports busy meanwhile.
// ----------------------------------------------------------------------------
module trme_dmem (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire trme_pkg::dmem_req_t req,
  output      trme_pkg::value_t   rdata,
  output      logic               busy
);
  import trme_pkg::*;

  localparam mem_addr_t LAST_ADDR = {MEM_ADDR_BITS{1'b1}};

  value_t    mem [2**MEM_ADDR_BITS];
  mem_addr_t clr_addr;
  logic      clearing;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + mem_addr_t'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // memory array: sweep write, item write or item read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

  assign busy = clearing;

endmodule
`default_nettype wire

[sv/trme_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trme_check - port-level checks of the execute core
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module trme_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic        reg_written,
  input wire logic [2:0]  reg_index,
  input wire logic [18:0] reg_value,
  input wire logic        mem_written,
  input wire logic [14:0] mem_address
);
  import trme_pkg::*;

  // memory sweep blocks input right after reset, and the output is not valid
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("input not stalled or output valid after reset");

  // no register write means zeroed register fields
  a_no_reg_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reg_written) |-> (reg_index == '0 && reg_value == '0))
    else $error("register fields set without a register write");

  // a store is ok and writes no register; no store means zero address
  a_store_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mem_written ? (status == ST_OK && !reg_written)
                               : (mem_address == '0)))
    else $error("inconsistent store result");

  // error results change nothing
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (!reg_written && !mem_written))
    else $error("error result reports a write");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(reg_value)))
    else $error("stalled item changed");

endmodule

bind toy_register_memory_machine_execute_core trme_check u_trme_check (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .reg_written (reg_written),
  .reg_index   (reg_index),
  .reg_value   (reg_value),
  .mem_written (mem_written),
  .mem_address (mem_address)
);
`default_nettype wire
